// ===== hdl/xpr_pkg.sv =====
// Shared types, protocol constants and the CRC step of the XMODEM packet receiver.
`timescale 1ns / 1ps

package xpr_pkg;

  localparam int unsigned PAYLOAD_BYTES = 128;
  localparam int unsigned CountW = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned IndexW = $clog2(PAYLOAD_BYTES);

  localparam logic [7:0] B_SOH   = 8'h01;
  localparam logic [7:0] B_EOT   = 8'h04;
  localparam logic [7:0] B_ACK   = 8'h06;
  localparam logic [7:0] B_NAK   = 8'h15;
  localparam logic [7:0] B_CAN   = 8'h18;
  localparam logic [7:0] B_PAD   = 8'h1A;
  localparam logic [7:0] B_REQ_C = 8'h43;
  localparam logic [7:0] B_FF    = 8'hFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_CRC_MODE     = 2'd0,
    CFG_MAX_ATTEMPTS = 2'd1,
    CFG_CANCEL_LIMIT = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_e;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_BLK     = 4'd1,
    PH_CBLK    = 4'd2,
    PH_DATA    = 4'd3,
    PH_CHK1    = 4'd4,
    PH_CHK2    = 4'd5,
    PH_DRAIN   = 4'd6,
    PH_EOF     = 4'd7,
    PH_CANCEL  = 4'd8,
    PH_EXHAUST = 4'd9
  } phase_e;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_ACCEPT = 2'd1;
  localparam logic [1:0] EV_REJECT = 2'd2;

  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_EOF     = 2'd1;
  localparam logic [1:0] ST_CANCEL  = 2'd2;
  localparam logic [1:0] ST_EXHAUST = 2'd3;

  typedef struct packed {
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              data_valid;
    logic [7:0]        data_byte;
    logic [IndexW-1:0] data_index;
    logic [1:0]        packet_event;
    logic [7:0]        keep_length;
    logic [7:0]        block_number;
    logic [1:0]        session_status;
    logic              last_of_run;
  } result_t;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hdl/xpr_out_buf.sv =====
// Output register with a one-entry skid stage for the receiver results.
`timescale 1ns / 1ps

module xpr_out_buf
  import xpr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    take;

  assign take = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // Upstream is stalled while the skid stage holds a result.
      if (take) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || take) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

// ===== hdl/xmodem_packet_receiver.sv =====
// Top level of the XMODEM 128-byte packet receiver: session state and per-request logic.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                 Payload
//  input     in         in_valid_i / in_stall_o   op_i, rx_byte_i
//  output    out        out_valid_o / out_stall_i tx, data, event, keep, block, status
//  config    in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One input request is taken every cycle while in_stall_o is low. The whole step
// for a request (phase update, CRC byte update, sum, padding tracking, verdict)
// is combinational between the state registers and the output register, where
// its result is registered. A request yields at most one result.
// The output register has a skid stage behind it; in_stall_o rises only when
// both hold a result, so a downstream stall backs up after two results.
// Reset clears the session to a header hunt for block 1 and loads the register
// defaults (CRC mode, 20 attempts, cancel after 3 CAN bytes).

module xmodem_packet_receiver
  import xpr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              tx_valid_o,
  output logic [7:0]        tx_byte_o,
  output logic              data_valid_o,
  output logic [7:0]        data_byte_o,
  output logic [IndexW-1:0] data_index_o,
  output logic [1:0]        packet_event_o,
  output logic [7:0]        keep_length_o,
  output logic [7:0]        block_number_o,
  output logic [1:0]        session_status_o,
  output logic              last_of_run_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_wdata_i
);

  // Configuration registers.
  logic       crc_mode_q;
  logic [7:0] max_att_q;
  logic [3:0] cancel_lim_q;

  // Session state.
  phase_e             phase_q, phase_d;
  logic [7:0]         expected_q, expected_d;
  logic [7:0]         got_blk_q, got_blk_d;
  logic [7:0]         got_cblk_q, got_cblk_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [15:0]        crc_q, crc_d;
  logic [7:0]         sum_q, sum_d;
  logic [7:0]         crc_hi_q, crc_hi_d;
  logic [3:0]         cancels_q, cancels_d;
  logic               hunt_started_q, hunt_started_d;
  logic [7:0]         attempts_q, attempts_d;
  logic [7:0]         keep_q, keep_d;
  logic [7:0]         pad_q, pad_d;

  logic    accept;
  logic    res_valid;
  result_t res;

  // Shared pieces of the step logic.
  logic [7:0]        att_inc;
  logic [7:0]        req_byte;
  logic              frame_ok;
  logic              check_ok;
  logic [7:0]        keep_len;
  logic [3:0]        cancels_inc;
  logic [CountW-1:0] count_inc;
  logic [IndexW-1:0] idx;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    att_inc     = (attempts_q != 8'hFF) ? attempts_q + 8'd1 : attempts_q;
    req_byte    = crc_mode_q ? B_REQ_C : B_NAK;
    frame_ok    = (got_blk_q ^ got_cblk_q) == B_FF;
    keep_len    = (pad_q >= 8'd3) ? keep_q : 8'(PAYLOAD_BYTES);
    cancels_inc = (cancels_q != 4'hF) ? cancels_q + 4'd1 : cancels_q;
    count_inc   = count_q + CountW'(1);
    idx         = count_q[IndexW-1:0];
    if (phase_q == PH_CHK2) begin
      check_ok = {crc_hi_q, rx_byte_i} == crc_q;
    end else begin
      check_ok = rx_byte_i == sum_q;
    end
  end

  always_comb begin
    phase_d        = phase_q;
    expected_d     = expected_q;
    got_blk_d      = got_blk_q;
    got_cblk_d     = got_cblk_q;
    count_d        = count_q;
    crc_d          = crc_q;
    sum_d          = sum_q;
    crc_hi_d       = crc_hi_q;
    cancels_d      = cancels_q;
    hunt_started_d = hunt_started_q;
    attempts_d     = attempts_q;
    keep_d         = keep_q;
    pad_d          = pad_q;
    res_valid      = 1'b0;
    res            = '0;

    if (accept) begin
      case (op_i)
        OP_BYTE: begin
          unique case (phase_q)
            PH_HUNT: begin
              if (rx_byte_i == B_EOT && !hunt_started_q) begin
                // End of file only when EOT opens the hunt.
                phase_d      = PH_EOF;
                res_valid    = 1'b1;
                res.tx_valid = 1'b1;
                res.tx_byte  = B_ACK;
              end else begin
                hunt_started_d = 1'b1;
                if (rx_byte_i == B_SOH) begin
                  phase_d    = PH_BLK;
                  got_blk_d  = '0;
                  got_cblk_d = '0;
                  count_d    = '0;
                  crc_d      = '0;
                  sum_d      = '0;
                  crc_hi_d   = '0;
                  keep_d     = '0;
                  pad_d      = '0;
                end else if (rx_byte_i == B_CAN) begin
                  cancels_d = cancels_inc;
                  if (cancels_inc >= cancel_lim_q) begin
                    phase_d   = PH_CANCEL;
                    res_valid = 1'b1;
                  end
                end
              end
            end
            PH_BLK: begin
              got_blk_d = rx_byte_i;
              phase_d   = PH_CBLK;
            end
            PH_CBLK: begin
              got_cblk_d = rx_byte_i;
              phase_d    = PH_DATA;
            end
            PH_DATA: begin
              crc_d = crc_update(crc_q, rx_byte_i);
              sum_d = sum_q + rx_byte_i;
              if (rx_byte_i == B_PAD) begin
                pad_d = (pad_q != 8'hFF) ? pad_q + 8'd1 : pad_q;
              end else begin
                pad_d  = '0;
                keep_d = 8'(count_inc);
              end
              count_d = count_inc;
              if (count_inc >= CountW'(PAYLOAD_BYTES)) begin
                phase_d = PH_CHK1;
              end
              res_valid      = 1'b1;
              res.data_valid = 1'b1;
              res.data_byte  = rx_byte_i;
              res.data_index = idx;
            end
            PH_CHK1, PH_CHK2: begin
              if (phase_q == PH_CHK1 && crc_mode_q) begin
                crc_hi_d = rx_byte_i;
                phase_d  = PH_CHK2;
              end else begin
                res_valid          = 1'b1;
                res.block_number   = got_blk_q;
                res.packet_event   = EV_REJECT;
                cancels_d          = '0;
                hunt_started_d     = 1'b0;
                if (!frame_ok) begin
                  // Frame error: no reply, drain until the line goes quiet.
                  phase_d = PH_DRAIN;
                end else if (check_ok && got_blk_q == expected_q) begin
                  phase_d          = PH_HUNT;
                  expected_d       = expected_q + 8'd1;
                  attempts_d       = '0;
                  res.tx_valid     = 1'b1;
                  res.tx_byte      = B_ACK;
                  res.packet_event = EV_ACCEPT;
                  res.keep_length  = keep_len;
                end else if (check_ok && got_blk_q == expected_q - 8'd1) begin
                  // Duplicate of the previous block is re-acknowledged.
                  phase_d      = PH_HUNT;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = B_ACK;
                end else begin
                  attempts_d   = att_inc;
                  phase_d      = (att_inc >= max_att_q) ? PH_EXHAUST : PH_HUNT;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = req_byte;
                end
              end
            end
            default: begin
            end
          endcase
        end
        OP_TIMEOUT: begin
          if (phase_q inside {PH_HUNT, PH_DRAIN, PH_BLK, PH_CBLK, PH_DATA, PH_CHK1,
                              PH_CHK2}) begin
            attempts_d     = att_inc;
            cancels_d      = '0;
            hunt_started_d = 1'b0;
            phase_d        = (att_inc >= max_att_q) ? PH_EXHAUST : PH_HUNT;
            res_valid      = 1'b1;
            res.tx_valid   = 1'b1;
            res.tx_byte    = req_byte;
            // A timeout inside a packet also rejects that packet.
            if (!(phase_q inside {PH_HUNT, PH_DRAIN})) begin
              res.packet_event = EV_REJECT;
              res.block_number = got_blk_q;
            end
          end
        end
        OP_RESTART: begin
          phase_d        = PH_HUNT;
          cancels_d      = '0;
          hunt_started_d = 1'b0;
          expected_d     = 8'd1;
          got_blk_d      = '0;
          got_cblk_d     = '0;
          count_d        = '0;
          crc_d          = '0;
          sum_d          = '0;
          crc_hi_d       = '0;
          attempts_d     = '0;
          keep_d         = '0;
          pad_d          = '0;
        end
        default: begin
        end
      endcase
    end

    // Status reflects the phase after this request.
    case (phase_d)
      PH_EOF:     res.session_status = ST_EOF;
      PH_CANCEL:  res.session_status = ST_CANCEL;
      PH_EXHAUST: res.session_status = ST_EXHAUST;
      default:    res.session_status = ST_RUNNING;
    endcase
    res.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_mode_q   <= 1'b1;
      max_att_q    <= 8'd20;
      cancel_lim_q <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CRC_MODE:     crc_mode_q   <= cfg_wdata_i[0];
        CFG_MAX_ATTEMPTS: max_att_q    <= cfg_wdata_i;
        CFG_CANCEL_LIMIT: cancel_lim_q <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT;
      expected_q     <= 8'd1;
      got_blk_q      <= '0;
      got_cblk_q     <= '0;
      count_q        <= '0;
      crc_q          <= '0;
      sum_q          <= '0;
      crc_hi_q       <= '0;
      cancels_q      <= '0;
      hunt_started_q <= 1'b0;
      attempts_q     <= '0;
      keep_q         <= '0;
      pad_q          <= '0;
    end else begin
      phase_q        <= phase_d;
      expected_q     <= expected_d;
      got_blk_q      <= got_blk_d;
      got_cblk_q     <= got_cblk_d;
      count_q        <= count_d;
      crc_q          <= crc_d;
      sum_q          <= sum_d;
      crc_hi_q       <= crc_hi_d;
      cancels_q      <= cancels_d;
      hunt_started_q <= hunt_started_d;
      attempts_q     <= attempts_d;
      keep_q         <= keep_d;
      pad_q          <= pad_d;
    end
  end

  result_t out_data;

  xpr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign tx_valid_o       = out_data.tx_valid;
  assign tx_byte_o        = out_data.tx_byte;
  assign data_valid_o     = out_data.data_valid;
  assign data_byte_o      = out_data.data_byte;
  assign data_index_o     = out_data.data_index;
  assign packet_event_o   = out_data.packet_event;
  assign keep_length_o    = out_data.keep_length;
  assign block_number_o   = out_data.block_number;
  assign session_status_o = out_data.session_status;
  assign last_of_run_o    = out_data.last_of_run;

endmodule
